>>> rtl/rational_arithmetic_unit_core_defines.svh
// ---------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Word size, opcodes, status codes and sequencer states.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [63:0] LIM = 64'(1) << (WORD_BITS - 1);

    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 72;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NEG  = 3'd4,
        OP_CMP  = 3'd5,
        OP_NORM = 3'd6,
        OP_RSVD = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN,
        S_DONE
    } t_state;

endpackage

>>> rtl/rational_arithmetic_unit_core.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit core
// Exact fraction add/sub/mul/div/negate/compare/normalize, reduced by gcd.
// ---------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)
// s_axis   in   operation[2:0] a_num[34:3] a_den[66:35] b_num[98:67] b_den[130:99]
// m_axis   out  res_num[31:0] res_den[62:32] order[64:63] status[66:65]
//
// After an input beat: a multiply phase, a sum step, a binary gcd loop, 2 x 64 restoring
// divide steps, a finish step and the output load, in that order. Compare, the unused
// opcode and a zero denominator skip the gcd, divide and finish steps. Ready returns the
// cycle after the output register loads.
// Reset is synchronous, active low; no clearing pass.
// Input is taken only when idle; a finished result waits while the output is full.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // operation, a_num, a_den, b_num, b_den
    input  logic [rau_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // res_num, res_den, order, status
    output logic [rau_pkg::OUT_BITS-1:0] m_axis_tdata
);

    rau_pkg::t_state r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_ovalid, n_ovalid;

    logic [2:0]  r_op;
    logic signed [31:0] r_an, r_ad, r_bn, r_bd;
    logic signed [63:0] r_p0, r_p1, r_p2, n_p0, n_p1, n_p2;
    logic [63:0] r_nm, r_dm, r_x, r_y, r_g, r_rem, r_quo, r_nq;
    logic [63:0] n_nm, n_dm, n_x, n_y, n_g, n_rem, n_quo, n_nq;
    logic        r_nneg, r_dneg, n_nneg, n_dneg;
    logic [5:0]  r_k, n_k;
    logic [31:0] r_fnum, n_fnum;
    logic [30:0] r_fden, n_fden;
    logic [1:0]  r_ford, r_fstat, n_ford, n_fstat;
    logic [rau_pkg::OUT_BITS-1:0] r_odata, n_odata;

    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    logic signed [64:0] sum;
    logic [64:0] sum_mag, rem_sh, diff;
    logic        ge, neg, ovf;
    logic [63:0] num_tc;

    assign m_p = m_a * m_b;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_cnt[1:0])
            2'd0: begin
                m_a = r_an;
                case (r_op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_DIV,
                    rau_pkg::OP_CMP: m_b = r_bd;
                    rau_pkg::OP_MUL: m_b = r_bn;
                    rau_pkg::OP_NEG: m_b = -32'sd1;
                    rau_pkg::OP_NORM: m_b = 32'sd1;
                    default: m_a = '0;
                endcase
            end
            2'd1: begin
                case (r_op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
                        m_a = r_bn;
                        m_b = r_ad;
                    end
                    default: m_a = '0;
                endcase
            end
            default: begin
                m_a = r_ad;
                case (r_op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL: m_b = r_bd;
                    rau_pkg::OP_DIV: m_b = r_bn;
                    rau_pkg::OP_NEG, rau_pkg::OP_NORM: m_b = 32'sd1;
                    default: m_a = '0;
                endcase
            end
        endcase
    end

    always_comb begin
        sum = {r_p0[63], r_p0} + ((r_op == rau_pkg::OP_SUB) ? -{r_p1[63], r_p1}
                                                              : {r_p1[63], r_p1});
        sum_mag = sum[64] ? 65'(-sum) : 65'(sum);
        rem_sh  = {r_rem, r_quo[63]};
        ge      = rem_sh >= {1'b0, r_g};
        diff    = rem_sh - {1'b0, r_g};
        neg     = (r_nq != '0) && (r_nneg != r_dneg);
        ovf     = (r_quo > rau_pkg::LIM - 64'd1) ||
                  (neg ? (r_nq > rau_pkg::LIM) : (r_nq > rau_pkg::LIM - 64'd1));
        num_tc  = neg ? -r_nq : r_nq;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovalid = r_ovalid;
        n_odata = r_odata;
        n_p0 = r_p0; n_p1 = r_p1; n_p2 = r_p2;
        n_nm = r_nm; n_dm = r_dm; n_x = r_x; n_y = r_y; n_g = r_g;
        n_rem = r_rem; n_quo = r_quo; n_nq = r_nq;
        n_nneg = r_nneg; n_dneg = r_dneg; n_k = r_k;
        n_fnum = r_fnum; n_fden = r_fden; n_ford = r_ford; n_fstat = r_fstat;

        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;

        case (r_state)
            rau_pkg::S_IDLE: begin
                n_cnt = '0;
                if (s_axis_tvalid) n_state = rau_pkg::S_MUL;
            end
            rau_pkg::S_MUL: begin
                case (r_cnt[1:0])
                    2'd0: n_p0 = m_p;
                    2'd1: n_p1 = m_p;
                    default: n_p2 = m_p;
                endcase
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd2) n_state = rau_pkg::S_SUM;
            end
            rau_pkg::S_SUM: begin
                n_fnum = '0; n_fden = 31'd1; n_ford = rau_pkg::ORD_LT;
                n_fstat = rau_pkg::ST_OK;
                n_nneg = sum[64];
                n_nm = sum_mag[63:0];
                n_x  = sum_mag[63:0];
                n_dneg = r_p2[63];
                n_dm = r_p2[63] ? 64'(-r_p2) : 64'(r_p2);
                n_y  = r_p2[63] ? 64'(-r_p2) : 64'(r_p2);
                n_k  = '0;
                if (r_op == rau_pkg::OP_CMP) begin
                    n_ford = (r_p0 < r_p1) ? rau_pkg::ORD_LT :
                             ((r_p0 > r_p1) ? rau_pkg::ORD_GT : rau_pkg::ORD_EQ);
                    n_state = rau_pkg::S_DONE;
                end else if (r_op == rau_pkg::OP_RSVD) begin
                    n_state = rau_pkg::S_DONE;
                end else if (r_p2 == '0) begin
                    n_fstat = rau_pkg::ST_DIV0;
                    n_state = rau_pkg::S_DONE;
                end else begin
                    n_state = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD: begin
                if (r_x == '0) begin
                    n_g = r_y << r_k;
                    n_quo = r_nm;
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = rau_pkg::S_DIVN;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 6'd1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = (r_x - r_y) >> 1;
                end else begin
                    n_y = (r_y - r_x) >> 1;
                end
            end
            rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
                n_rem = ge ? diff[63:0] : rem_sh[63:0];
                n_quo = {r_quo[62:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    if (r_state == rau_pkg::S_DIVN) begin
                        n_nq = {r_quo[62:0], ge};
                        n_quo = r_dm;
                        n_rem = '0;
                        n_state = rau_pkg::S_DIVD;
                    end else begin
                        n_state = rau_pkg::S_FIN;
                    end
                end
            end
            rau_pkg::S_FIN: begin
                if (ovf) begin
                    n_fstat = rau_pkg::ST_OVF;
                end else begin
                    n_fnum = num_tc[31:0];
                    n_fden = r_quo[30:0];
                end
                n_state = rau_pkg::S_DONE;
            end
            rau_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {5'd0, r_fstat, r_ford, r_fden, r_fnum};
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rau_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rau_pkg::S_IDLE && s_axis_tvalid) begin
            r_op <= s_axis_tdata[2:0];
            r_an <= s_axis_tdata[34:3];
            r_ad <= s_axis_tdata[66:35];
            r_bn <= s_axis_tdata[98:67];
            r_bd <= s_axis_tdata[130:99];
        end
        r_p0 <= n_p0; r_p1 <= n_p1; r_p2 <= n_p2;
        r_nm <= n_nm; r_dm <= n_dm; r_x <= n_x; r_y <= n_y; r_g <= n_g;
        r_rem <= n_rem; r_quo <= n_quo; r_nq <= n_nq;
        r_nneg <= n_nneg; r_dneg <= n_dneg; r_k <= n_k;
        r_fnum <= n_fnum; r_fden <= n_fden; r_ford <= n_ford; r_fstat <= n_fstat;
        r_odata <= n_odata;
    end

    assign s_axis_tready = (r_state == rau_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

>>> rtl/rau_checker.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_defines.svh"

module rau_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [rau_pkg::IN_BITS-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rau_pkg::OUT_BITS-1:0] m_axis_tdata
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready &&
                    (s_axis_tdata[2:0] != rau_pkg::OP_RSVD || 1'b1);

    `RAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
    `RAU_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_beat, !s_axis_tready, "ready high right after an input beat")
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[66:65] != rau_pkg::ST_OK, m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:32] == 31'd1 && m_axis_tdata[64:63] == rau_pkg::ORD_LT, "error result is not 0/1")
    `RAU_ASSERT_IMP(a_den_pos, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[62:32] != 31'd0, "zero result denominator")
    `RAU_ASSERT_IMP(a_codes, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[66:65] != 2'd3 && m_axis_tdata[64:63] != 2'd3, "bad order or status code")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
